FILE: hw/rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// Bezier path stepper package
// Word types, register indexes, reset values and state encodings shared by
// the stepper, its curve sequencer and the port checker.
// ----------------------------------------------------------------------------
package bps_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROL_A      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROL_B      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_POINT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROL_COUNT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOVE_SPEED     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRAIL_INTERVAL = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRAIN_STEP     = 3'd6;

   // Register reset values
   localparam logic [15:0] MOVE_SPEED_RESET     = 16'd655;
   localparam logic [7:0]  TRAIL_INTERVAL_RESET = 8'd4;
   localparam logic [7:0]  DRAIN_STEP_RESET     = 8'd2;

   // Curve shapes
   localparam logic [1:0] COUNT_QUADRATIC = 2'd1;
   localparam logic [1:0] COUNT_CUBIC     = 2'd2;

   // Action codes
   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_SHOT = 1'b1;

   localparam int TRAIL_COUNT_W = 6;

   typedef logic signed [15:0] coord_type;
   // packed z:y:x
   typedef logic [47:0] point_type;

   typedef struct packed {
      logic      action;
      coord_type start_x;
      coord_type start_y;
      coord_type start_z;
   } req_word_type;

   typedef struct packed {
      coord_type                pos_x;
      coord_type                pos_y;
      coord_type                pos_z;
      logic                     attacking;
      logic                     ended;
      logic                     end_event;
      logic                     trail_push;
      logic                     trail_pop;
      logic [TRAIL_COUNT_W-1:0] trail_count;
   } rsp_word_type;

   // Stepper to curve sequencer
   typedef struct packed {
      logic        start;
      logic        cubic;
      logic [15:0] weight;
   } curve_cmd_type;

   // Curve sequencer to stepper
   typedef struct packed {
      logic      done;
      point_type point;
   } curve_result_type;

   typedef enum logic [1:0] {
      STP_IDLE,
      STP_EVAL,
      STP_FINISH
   } stp_state_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_LOAD,
      SEQ_MUL,
      SEQ_ADD,
      SEQ_DROP,
      SEQ_DONE
   } seq_state_type;

   // One axis of a packed point
   function automatic coord_type axis_of(input point_type p, input logic [1:0] k);
      coord_type v;
      case (k)
         2'd0:    v = p[15:0];
         2'd1:    v = p[31:16];
         default: v = p[47:32];
      endcase
      return v;
   endfunction

endpackage

FILE: hw/rtl/bps_stream_if.sv
// ----------------------------------------------------------------------------
// Bezier path stepper stream channel
// Valid/ready channel carrying one word of the given payload type.
// ----------------------------------------------------------------------------
interface bps_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source  (output valid, output payload, input ready);
   modport sink    (input valid, input payload, output ready);
   modport monitor (input valid, input payload, input ready);
endinterface

FILE: hw/rtl/bps_lerp_unit.sv
// ----------------------------------------------------------------------------
// Bezier path stepper interpolation unit
// Shared lerp: p + round(w * (q - p) / 2^16), half rounded up.
// Stage one registers the product, stage two adds it to p.
// ----------------------------------------------------------------------------
module bps_lerp_unit (
   input  logic               clock,
   input  logic               load,
   input  logic [15:0]        weight,
   input  bps_pkg::coord_type p_value,
   input  bps_pkg::coord_type q_value,
   output bps_pkg::coord_type result
);
   import bps_pkg::*;

   logic signed [16:0] diff;
   logic signed [16:0] weight_s;
   logic signed [33:0] prod_in, prod_ff;
   coord_type          base_in, base_ff;
   logic signed [33:0] rounded;
   logic signed [17:0] frac;
   logic signed [17:0] sum;

   // Multiply stage
   always_comb begin
      diff     = {q_value[15], q_value} - {p_value[15], p_value};
      weight_s = {1'b0, weight};
      prod_in  = prod_ff;
      base_in  = base_ff;
      if (load) begin
         prod_in = weight_s * diff;
         base_in = p_value;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      base_ff <= base_in;
   end

   // Round and add; the result always lies between p and q
   always_comb begin
      rounded = prod_ff + 34'sd32768;
      frac    = rounded[33:16];
      sum     = {{2{base_ff[15]}}, base_ff} + frac;
      result  = sum[15:0];
   end

endmodule

FILE: hw/rtl/bps_curve_seq.sv
// ----------------------------------------------------------------------------
// Bezier path stepper curve sequencer
// De Casteljau evaluation, one axis at a time, through the shared lerp unit.
// The points of a round sit in a short shift queue: each lerp takes the two
// head entries and writes its result at the tail; a drop ends the round.
// ----------------------------------------------------------------------------
module bps_curve_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  bps_pkg::curve_cmd_type    cmd,
   input  bps_pkg::point_type        start_point,
   input  bps_pkg::point_type        control_a,
   input  bps_pkg::point_type        control_b,
   input  bps_pkg::point_type        target_point,
   output bps_pkg::curve_result_type status
);
   import bps_pkg::*;

   seq_state_type state_ff, state_in;
   logic [1:0]    axis_ff, axis_in;
   logic [2:0]    len_ff, len_in;
   logic [1:0]    rem_ff, rem_in;
   logic          cubic_ff, cubic_in;
   logic [15:0]   weight_ff, weight_in;
   coord_type     w_ff [4];
   coord_type     w_in [4];
   point_type     res_ff, res_in;
   logic [2:0]    tail;
   logic          lerp_load;
   coord_type     lerp_out;

   bps_lerp_unit u_lerp (
      .clock   (clock),
      .load    (lerp_load),
      .weight  (weight_ff),
      .p_value (w_ff[0]),
      .q_value (w_ff[1]),
      .result  (lerp_out)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: if (cmd.start) state_in = SEQ_LOAD;
         SEQ_LOAD: state_in = SEQ_MUL;
         SEQ_MUL:  state_in = SEQ_ADD;
         SEQ_ADD:  state_in = (rem_ff == 2'd1) ? SEQ_DROP : SEQ_MUL;
         SEQ_DROP: begin
            if (len_ff == 3'd2) begin
               state_in = (axis_ff == 2'd2) ? SEQ_DONE : SEQ_LOAD;
            end else begin
               state_in = SEQ_MUL;
            end
         end
         SEQ_DONE: state_in = SEQ_IDLE;
         default:  state_in = SEQ_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      lerp_load    = (state_ff == SEQ_MUL);
      status.done  = (state_ff == SEQ_DONE);
      status.point = res_ff;
   end

   // Queue and counters
   always_comb begin
      axis_in   = axis_ff;
      len_in    = len_ff;
      rem_in    = rem_ff;
      cubic_in  = cubic_ff;
      weight_in = weight_ff;
      res_in    = res_ff;
      for (int j = 0; j < 4; j++) w_in[j] = w_ff[j];
      tail = len_ff - 3'd1;

      case (state_ff)
         SEQ_IDLE: begin
            if (cmd.start) begin
               axis_in   = 2'd0;
               cubic_in  = cmd.cubic;
               weight_in = cmd.weight;
            end
         end
         SEQ_LOAD: begin
            w_in[0] = axis_of(start_point, axis_ff);
            w_in[1] = axis_of(control_a, axis_ff);
            w_in[2] = cubic_ff ? axis_of(control_b, axis_ff) : axis_of(target_point, axis_ff);
            w_in[3] = axis_of(target_point, axis_ff);
            len_in  = cubic_ff ? 3'd4 : 3'd3;
            rem_in  = cubic_ff ? 2'd3 : 2'd2;
         end
         SEQ_ADD: begin
            // pop the head, append the new point at the tail
            w_in[0] = w_ff[1];
            w_in[1] = w_ff[2];
            w_in[2] = w_ff[3];
            w_in[tail[1:0]] = lerp_out;
            rem_in = rem_ff - 2'd1;
         end
         SEQ_DROP: begin
            // discard the leftover point of the finished round
            w_in[0] = w_ff[1];
            w_in[1] = w_ff[2];
            w_in[2] = w_ff[3];
            len_in  = len_ff - 3'd1;
            if (len_ff == 3'd2) begin
               case (axis_ff)
                  2'd0:    res_in[15:0]  = w_ff[1];
                  2'd1:    res_in[31:16] = w_ff[1];
                  default: res_in[47:32] = w_ff[1];
               endcase
               axis_in = axis_ff + 2'd1;
            end else begin
               rem_in = 2'(len_ff - 3'd2);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff   <= axis_in;
      len_ff    <= len_in;
      rem_ff    <= rem_in;
      cubic_ff  <= cubic_in;
      weight_ff <= weight_in;
      res_ff    <= res_in;
      for (int j = 0; j < 4; j++) w_ff[j] <= w_in[j];
   end

endmodule

FILE: hw/rtl/bezier_path_stepper_with_trail.sv
// ----------------------------------------------------------------------------
// Bezier path stepper with trail
// Steps a quadratic or cubic Bezier path per tick word and reports trail
// push/pop events and the trail count; a shot word starts a new run.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | word
//  req_if    | in  | valid/ready   | action, start_x, start_y, start_z
//  rsp_if    | out | valid/ready   | pos_x/y/z, attacking, ended, end_event,
//            |     |               | trail_push, trail_pop, trail_count
//  csr_*     | in  | write enable  | csr_index, csr_wr_data
//
//  A shot, or a tick with no curve step, goes from acceptance to the finish
//  state and loads its result into the output register once that is free.
//  A curve tick runs the sequencer: the three axes share one 17x17 lerp
//  multiplier, 3 or 6 lerps per axis, with a load per axis and a drop
//  per round. A new word is accepted once the stepper is back in idle,
//  even while the previous result still waits in the output register.
//  Reset is synchronous and returns all but the result word to reset values.
// ----------------------------------------------------------------------------
module bezier_path_stepper_with_trail #(
   parameter int TRAIL_DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   bps_stream_if.sink                        req_if,
   bps_stream_if.source                      rsp_if,
   input  logic                              csr_wr_en,
   input  logic [bps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bps_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import bps_pkg::*;

   localparam int SIZE_W = $clog2(TRAIL_DEPTH + 2);

   // Configuration registers
   point_type   ctrl_a_ff, ctrl_a_in;
   point_type   ctrl_b_ff, ctrl_b_in;
   point_type   target_ff, target_in;
   logic [1:0]  ccount_ff, ccount_in;
   logic [15:0] speed_ff, speed_in;
   logic [7:0]  interval_ff, interval_in;
   logic [7:0]  drain_ff, drain_in;

   // Run state
   stp_state_type     state_ff, state_in;
   point_type         pos_ff, pos_in;
   point_type         start_ff, start_in;
   logic [16:0]       t_ff, t_in;
   logic              active_ff, active_in;
   logic              ended_ff, ended_in;
   logic [7:0]        icount_ff, icount_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic              tick_ff, tick_in;
   logic              push_ff, push_in;
   logic              pop_ff, pop_in;

   // Output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // Tick stage
   logic [8:0]          ic_sum;
   logic [7:0]          ic_sat;
   logic                trail_hit;
   logic                pop_now;
   logic                push_now;
   logic [SIZE_W-1:0]   size_next;
   logic                active_next;
   logic                curve_on;
   logic                req_fire;
   logic                eval_go;
   logic                out_free;
   logic                rsp_load;
   logic                end_hit;
   logic [SIZE_W+5:0]   size_ext;

   curve_cmd_type    curve_cmd;
   curve_result_type curve_res;

   bps_curve_seq u_curve (
      .clock        (clock),
      .reset        (reset),
      .cmd          (curve_cmd),
      .start_point  (start_ff),
      .control_a    (ctrl_a_ff),
      .control_b    (ctrl_b_ff),
      .target_point (target_ff),
      .status       (curve_res)
   );

   // Interval counter and trail events of a tick
   always_comb begin
      req_fire    = req_if.valid && (state_ff == STP_IDLE);
      ic_sum      = {1'b0, icount_ff} + (ended_ff ? {1'b0, drain_ff} : 9'd1);
      ic_sat      = ic_sum[8] ? 8'hFF : ic_sum[7:0];
      trail_hit   = active_ff && (ic_sat >= interval_ff);
      pop_now     = 1'b0;
      push_now    = 1'b0;
      size_next   = size_ff;
      active_next = active_ff;
      if (trail_hit) begin
         if (ended_ff) begin
            pop_now     = (size_ff != '0);
            size_next   = size_ff - SIZE_W'(pop_now);
            active_next = (size_next != '0);
         end else begin
            pop_now   = (size_ff > SIZE_W'(TRAIL_DEPTH));
            push_now  = 1'b1;
            size_next = size_ff - SIZE_W'(pop_now) + SIZE_W'(1);
         end
      end
      curve_on = active_next && !t_ff[16] &&
                 ((ccount_ff == COUNT_QUADRATIC) || (ccount_ff == COUNT_CUBIC));
      eval_go  = req_fire && (req_if.payload.action == ACTION_TICK) && curve_on;
      out_free = !rsp_valid_ff || rsp_if.ready;
      end_hit  = tick_ff && active_ff && t_ff[16];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STP_IDLE:   if (req_fire) state_in = eval_go ? STP_EVAL : STP_FINISH;
         STP_EVAL:   if (curve_res.done) state_in = STP_FINISH;
         STP_FINISH: if (out_free) state_in = STP_IDLE;
         default:    state_in = STP_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_if.ready     = (state_ff == STP_IDLE);
      curve_cmd.start  = eval_go;
      curve_cmd.cubic  = (ccount_ff == COUNT_CUBIC);
      curve_cmd.weight = t_ff[15:0];
      rsp_load         = (state_ff == STP_FINISH) && out_free;
      rsp_if.valid     = rsp_valid_ff;
      rsp_if.payload   = rsp_word_ff;
   end

   // Configuration writes
   always_comb begin
      ctrl_a_in   = ctrl_a_ff;
      ctrl_b_in   = ctrl_b_ff;
      target_in   = target_ff;
      ccount_in   = ccount_ff;
      speed_in    = speed_ff;
      interval_in = interval_ff;
      drain_in    = drain_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CONTROL_A:      ctrl_a_in   = csr_wr_data;
            CSR_CONTROL_B:      ctrl_b_in   = csr_wr_data;
            CSR_TARGET_POINT:   target_in   = csr_wr_data;
            CSR_CONTROL_COUNT:  ccount_in   = csr_wr_data[1:0];
            CSR_MOVE_SPEED:     speed_in    = csr_wr_data[15:0];
            CSR_TRAIL_INTERVAL: interval_in = csr_wr_data[7:0];
            CSR_DRAIN_STEP:     drain_in    = csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   // Run state updates
   always_comb begin
      pos_in    = pos_ff;
      start_in  = start_ff;
      t_in      = t_ff;
      active_in = active_ff;
      ended_in  = ended_ff;
      icount_in = icount_ff;
      size_in   = size_ff;
      tick_in   = tick_ff;
      push_in   = push_ff;
      pop_in    = pop_ff;

      if (req_fire) begin
         push_in = 1'b0;
         pop_in  = 1'b0;
         tick_in = 1'b0;
         if (req_if.payload.action == ACTION_SHOT) begin
            // a shot during a run is ignored
            if (!active_ff) begin
               active_in = 1'b1;
               ended_in  = 1'b0;
               start_in  = {req_if.payload.start_z, req_if.payload.start_y,
                            req_if.payload.start_x};
               pos_in    = {req_if.payload.start_z, req_if.payload.start_y,
                            req_if.payload.start_x};
               t_in      = '0;
               icount_in = '0;
               size_in   = '0;
            end
         end else begin
            tick_in   = 1'b1;
            icount_in = ic_sat;
            size_in   = size_next;
            active_in = active_next;
            push_in   = push_now;
            pop_in    = pop_now;
         end
      end

      // curve point at the old t, then step t
      if ((state_ff == STP_EVAL) && curve_res.done) begin
         pos_in = curve_res.point;
         t_in   = t_ff + {1'b0, speed_ff};
      end

      if (rsp_load) begin
         ended_in = ended_ff || end_hit;
      end
   end

   // Result word
   always_comb begin
      size_ext                = {{TRAIL_COUNT_W{1'b0}}, size_ff};
      rsp_valid_in            = rsp_valid_ff && !rsp_if.ready;
      rsp_word_in             = rsp_word_ff;
      if (rsp_load) begin
         rsp_valid_in            = 1'b1;
         rsp_word_in.pos_x       = pos_ff[15:0];
         rsp_word_in.pos_y       = pos_ff[31:16];
         rsp_word_in.pos_z       = pos_ff[47:32];
         rsp_word_in.attacking   = active_ff;
         rsp_word_in.ended       = ended_ff || end_hit;
         rsp_word_in.end_event   = end_hit;
         rsp_word_in.trail_push  = push_ff;
         rsp_word_in.trail_pop   = pop_ff;
         rsp_word_in.trail_count = size_ext[TRAIL_COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STP_IDLE;
         ctrl_a_ff    <= '0;
         ctrl_b_ff    <= '0;
         target_ff    <= '0;
         ccount_ff    <= '0;
         speed_ff     <= MOVE_SPEED_RESET;
         interval_ff  <= TRAIL_INTERVAL_RESET;
         drain_ff     <= DRAIN_STEP_RESET;
         pos_ff       <= '0;
         start_ff     <= '0;
         t_ff         <= '0;
         active_ff    <= 1'b0;
         ended_ff     <= 1'b1;
         icount_ff    <= '0;
         size_ff      <= '0;
         tick_ff      <= 1'b0;
         push_ff      <= 1'b0;
         pop_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctrl_a_ff    <= ctrl_a_in;
         ctrl_b_ff    <= ctrl_b_in;
         target_ff    <= target_in;
         ccount_ff    <= ccount_in;
         speed_ff     <= speed_in;
         interval_ff  <= interval_in;
         drain_ff     <= drain_in;
         pos_ff       <= pos_in;
         start_ff     <= start_in;
         t_ff         <= t_in;
         active_ff    <= active_in;
         ended_ff     <= ended_in;
         icount_ff    <= icount_in;
         size_ff      <= size_in;
         tick_ff      <= tick_in;
         push_ff      <= push_in;
         pop_ff       <= pop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

endmodule

FILE: hw/rtl/bps_checker.sv
// ----------------------------------------------------------------------------
// Bezier path stepper port checker
// Checks relations between result flags and the request handshake as seen
// on the stepper's ports.
// ----------------------------------------------------------------------------
module bps_checker (
   input logic          clock,
   input logic          reset,
   bps_stream_if.sink   req_if,
   bps_stream_if.source rsp_if
);
   import bps_pkg::*;

   // A stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid && $stable(rsp_if.payload))
      else $error("result word changed while stalled");

   // One word at a time: not ready straight after an acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("request accepted while busy");

   // A push only happens in a run; if the curve is then ended, it ended now
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.payload.trail_push |->
         rsp_if.payload.attacking &&
         (!rsp_if.payload.ended || rsp_if.payload.end_event))
      else $error("trail push outside a live run");

   // End event only in a run, and it leaves the curve ended
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.payload.end_event |->
         rsp_if.payload.attacking && rsp_if.payload.ended)
      else $error("end event without an ended run");

   // No run means an empty trail
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.payload.attacking |-> rsp_if.payload.trail_count == '0)
      else $error("trail not empty outside a run");

endmodule

bind bezier_path_stepper_with_trail bps_checker u_bps_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);
